### src/flacmh_pkg.sv
// flacmh_pkg: types, constants and field decoders for the flac metadata header parser
// used by flac_metadata_header_parser and tb_top, no other dependencies
package flacmh_pkg;

	localparam int unsigned MaxWindow     = 65536;
	localparam int unsigned DefaultWindow = 32768;
	localparam int unsigned InfoBytes     = 18;
	localparam int unsigned InfoLen       = 34;

	localparam int unsigned TdataInWidth  = 8;
	localparam int unsigned TdataOutWidth = 120;
	localparam int unsigned TuserOutWidth = 4;

	typedef logic [InfoBytes-1:0][7:0] info_t;

	typedef enum logic [2:0] {
		ST_PARSING     = 3'd0,
		ST_HEADER_DONE = 3'd1,
		ST_PAYLOAD     = 3'd2,
		ST_BAD_MAGIC   = 3'd3,
		ST_TOO_LARGE   = 3'd4,
		ST_BAD_INFO    = 3'd5,
		ST_BAD_PARAMS  = 3'd6,
		ST_BIG_WINDOW  = 3'd7
	} status_t;

	typedef logic [3:0][7:0] magic_t;
	// "fLaC", first byte in index 0
	localparam magic_t Magic = {8'h43, 8'h61, 8'h4c, 8'h66};

	function automatic logic [19:0] f_rate(input info_t info);
		f_rate = {info[10], info[11], info[12][7:4]};
	endfunction

	function automatic logic [3:0] f_channels(input info_t info);
		f_channels = {1'b0, info[12][3:1]} + 4'd1;
	endfunction

	function automatic logic [5:0] f_bits(input info_t info);
		f_bits = {1'b0, info[12][0], info[13][7:4]} + 6'd1;
	endfunction

	function automatic logic [15:0] f_block(input info_t info);
		f_block = {info[2], info[3]};
	endfunction

	function automatic logic [23:0] f_window(input info_t info);
		logic [23:0] w;
		w = {info[7], info[8], info[9]};
		f_window = (w != 24'd0) ? w : 24'(DefaultWindow);
	endfunction

	function automatic logic [35:0] f_total(input info_t info);
		f_total = {info[13][3:0], info[14], info[15], info[16], info[17]};
	endfunction

endpackage

### src/flac_metadata_header_parser.sv
// flac_metadata_header_parser: magic check, metadata block walk, stream info capture
// depends on flacmh_pkg
//
// Usage:
// - s_tvalid/s_tready/s_tdata carry the flac stream one byte per transaction
//   (s_tdata[7:0] = stream_byte).
// - every input byte produces exactly one result transaction on m_tvalid/m_tready.
//   m_tuser holds status and payload_valid, m_tdata holds the passed-through byte
//   and the decoded stream info fields (see port comments).
// - once the last metadata block has ended and checks pass, status reports header
//   complete for that byte and payload for every byte after it; errors are sticky
//   and every later byte reports the error code with no payload.
// - cfg_we/cfg_wdata write the channel limit (reset value 2); write only while idle.
// - a byte accepted from the stream passes the input register, then the result
//   register, before it appears on the output.
// - throughput: one byte per cycle while the receiver does not stall; the parser
//   state updates once per byte in the logic between the two registers.
// - reset clears all parser state, the result register and the input valid flag; no clearing pass is needed.
// - when the receiver stalls, the result register and then the input register
//   hold, and s_tready drops until m_tready returns.
module flac_metadata_header_parser (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [3:0]                             cfg_wdata,     // channel_limit
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [flacmh_pkg::TdataInWidth-1:0]    s_tdata,       // stream_byte
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// payload_byte[7:0], rate_hz[27:8], channel_count[31:28], sample_bits[37:32],
	// largest_block[53:38], window_bytes[77:54], sample_total[113:78], zero pad
	output logic [flacmh_pkg::TdataOutWidth-1:0]   m_tdata,
	// status[2:0], payload_valid[3]
	output logic [flacmh_pkg::TuserOutWidth-1:0]   m_tuser
);

	typedef enum logic [2:0] {
		PH_MAGIC,
		PH_HEAD,
		PH_BODY,
		PH_DONE,
		PH_ERR
	} phase_t;

	// configuration
	logic [3:0] channel_limit_q;

	// parser state
	phase_t                phase_q, phase_n;
	logic [16:0]           offset_q, offset_n;
	logic [23:0]           remaining_q, remaining_n;
	logic [1:0]            hdr_idx_q, hdr_idx_n;
	logic [7:0]            kind_q, kind_n;
	logic                  seen_q, seen_n;
	flacmh_pkg::status_t   err_q, err_n;
	logic [16:0]           body_pos_q, body_pos_n;
	flacmh_pkg::info_t     info_q, info_n;

	// pipeline
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        valid_s2;
	logic [flacmh_pkg::TdataOutWidth-1:0] data_s2;
	logic [3:0]  user_s2;

	logic adv_s2, adv_s1;
	logic do_end, fin;
	logic pv;
	logic [25:0] end_sum;
	logic [5:0]  bits_n;
	flacmh_pkg::status_t status_n;

	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign s_tready = !valid_s1 || adv_s2;

	always_comb begin
		phase_n     = phase_q;
		offset_n    = offset_q;
		remaining_n = remaining_q;
		hdr_idx_n   = hdr_idx_q;
		kind_n      = kind_q;
		seen_n      = seen_q;
		err_n       = err_q;
		body_pos_n  = body_pos_q;
		info_n      = info_q;
		do_end      = 1'b0;
		fin         = 1'b0;
		pv          = 1'b0;
		end_sum     = 26'd0;
		bits_n      = 6'd0;

		unique case (phase_q)
			PH_MAGIC: begin
				if (byte_s1 != flacmh_pkg::Magic[hdr_idx_q]) begin
					phase_n = PH_ERR;
					err_n   = flacmh_pkg::ST_BAD_MAGIC;
				end else begin
					hdr_idx_n = hdr_idx_q + 2'd1;
					if (hdr_idx_q == 2'd3) begin
						phase_n  = PH_HEAD;
						offset_n = 17'd4;
					end
				end
			end
			PH_HEAD: begin
				if (hdr_idx_q == 2'd0) begin
					kind_n      = byte_s1;
					remaining_n = 24'd0;
				end else begin
					remaining_n = {remaining_q[15:0], byte_s1};
				end
				hdr_idx_n = hdr_idx_q + 2'd1;
				if (hdr_idx_q == 2'd3) begin
					if ((remaining_n > 24'(flacmh_pkg::MaxWindow)) ||
					    ((26'(offset_q) + 26'd4 + 26'(remaining_n)) >
					     26'(flacmh_pkg::MaxWindow))) begin
						phase_n = PH_ERR;
						err_n   = flacmh_pkg::ST_TOO_LARGE;
					end else begin
						body_pos_n = 17'd0;
						if (remaining_n == 24'd0) begin
							do_end = 1'b1;
						end else begin
							phase_n = PH_BODY;
						end
					end
				end
			end
			PH_BODY: begin
				if (kind_q[6:0] == 7'd0 && body_pos_q < 17'(flacmh_pkg::InfoBytes)) begin
					info_n[body_pos_q[4:0]] = byte_s1;
				end
				body_pos_n = body_pos_q + 17'd1;
				if (24'(body_pos_n) >= remaining_q) begin
					do_end = 1'b1;
				end
			end
			PH_DONE: begin
				pv = 1'b1;
			end
			PH_ERR: begin
			end
			default: begin
			end
		endcase

		// end of a metadata block: stream info length check, then final validation on the last one
		if (do_end) begin
			if (kind_n[6:0] == 7'd0 && remaining_n != 24'(flacmh_pkg::InfoLen)) begin
				phase_n = PH_ERR;
				err_n   = flacmh_pkg::ST_BAD_INFO;
			end else begin
				if (kind_n[6:0] == 7'd0) begin
					seen_n = 1'b1;
				end
				end_sum  = 26'(offset_q) + 26'd4 + 26'(remaining_n);
				offset_n = end_sum[16:0];
				bits_n   = flacmh_pkg::f_bits(info_n);
				if (!kind_n[7]) begin
					phase_n   = PH_HEAD;
					hdr_idx_n = 2'd0;
				end else if (!seen_n || flacmh_pkg::f_block(info_n) == 16'd0 ||
				             flacmh_pkg::f_channels(info_n) > channel_limit_q ||
				             (bits_n != 6'd8 && bits_n != 6'd16) ||
				             flacmh_pkg::f_rate(info_n) == 20'd0) begin
					phase_n = PH_ERR;
					err_n   = flacmh_pkg::ST_BAD_PARAMS;
				end else if (flacmh_pkg::f_window(info_n) >
				             24'(flacmh_pkg::MaxWindow)) begin
					phase_n = PH_ERR;
					err_n   = flacmh_pkg::ST_BIG_WINDOW;
				end else begin
					phase_n = PH_DONE;
					fin     = 1'b1;
				end
			end
		end

		if (phase_n == PH_ERR) begin
			status_n = err_n;
			pv       = 1'b0;
		end else if (fin) begin
			status_n = flacmh_pkg::ST_HEADER_DONE;
		end else if (phase_n == PH_DONE) begin
			status_n = flacmh_pkg::ST_PAYLOAD;
		end else begin
			status_n = flacmh_pkg::ST_PARSING;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_limit_q <= 4'd2;
		end else if (cfg_we) begin
			channel_limit_q <= cfg_wdata;
		end
	end

	// parser state and result data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_MAGIC;
			offset_q    <= 17'd0;
			remaining_q <= 24'd0;
			hdr_idx_q   <= 2'd0;
			kind_q      <= 8'd0;
			seen_q      <= 1'b0;
			err_q       <= flacmh_pkg::ST_PARSING;
			body_pos_q  <= 17'd0;
			info_q      <= '0;
			user_s2     <= '0;
			data_s2     <= '0;
		end else if (adv_s1) begin
			phase_q     <= phase_n;
			offset_q    <= offset_n;
			remaining_q <= remaining_n;
			hdr_idx_q   <= hdr_idx_n;
			kind_q      <= kind_n;
			seen_q      <= seen_n;
			err_q       <= err_n;
			body_pos_q  <= body_pos_n;
			info_q      <= info_n;
			user_s2     <= {pv, status_n};
			data_s2     <= {6'd0,
			                flacmh_pkg::f_total(info_n),
			                flacmh_pkg::f_window(info_n),
			                flacmh_pkg::f_block(info_n),
			                flacmh_pkg::f_bits(info_n),
			                flacmh_pkg::f_channels(info_n),
			                flacmh_pkg::f_rate(info_n),
			                pv ? byte_s1 : 8'd0};
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata[7:0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;
	assign m_tuser  = user_s2;

endmodule

### tb/tb_top.sv
// tb_top: self-checking bench for flac_metadata_header_parser, one header walk per run
// depends on flacmh_pkg and the parser rtl; a byte-level predictor checks every result

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ItemGoal = 1950;

	// walk states of the predictor
	typedef enum logic [2:0] {W_MAGIC, W_HEAD, W_BODY, W_DONE, W_ERR} walk_t;

	// what this run's stream does wrong, if anything
	typedef enum int {
		DEF_NONE, DEF_BAD_MAGIC, DEF_OVERSIZE, DEF_INFO_LENGTH, DEF_NO_INFO, DEF_ZERO_BLOCK,
		DEF_CHANNELS, DEF_DEPTH, DEF_ZERO_RATE, DEF_ZERO_LIMIT, DEF_BIG_WINDOW
	} defect_t;

	typedef enum int {PACE_FREE, PACE_RANDOM, PACE_PERIODIC, PACE_CHOKED} pace_t;

	typedef struct packed {
		flacmh_pkg::status_t status;
		logic         pay_valid;
		logic [7:0]   pay_byte;
		logic [19:0]  rate;
		logic [3:0]   chans;
		logic [5:0]   depth;
		logic [15:0]  max_blk;
		logic [23:0]  window;
		logic [35:0]  samples;
	} parse_report_t;

	logic                                   clk = 1'b0;
	logic                                   arst_n = 1'b0;
	logic                                   cfg_we = 1'b0;
	logic [3:0]                             cfg_wdata = 4'd0;
	logic                                   s_tvalid = 1'b0;
	logic                                   s_tready;
	logic [flacmh_pkg::TdataInWidth-1:0]    s_tdata = '0;      // stream_byte
	logic                                   m_tvalid;
	logic                                   m_tready = 1'b0;
	// payload_byte, rate_hz, channel_count, sample_bits, largest_block, window_bytes,
	// sample_total, zero pad
	logic [flacmh_pkg::TdataOutWidth-1:0]   m_tdata;
	logic [flacmh_pkg::TuserOutWidth-1:0]   m_tuser;           // status, payload_valid

	// predictor state
	walk_t        walk = W_MAGIC;
	int unsigned  blk_start = 0;
	logic [23:0]  blk_len = '0;
	logic [1:0]   hdr_idx = '0;
	logic [7:0]   blk_head = '0;
	logic         info_seen = 1'b0;
	flacmh_pkg::status_t err = flacmh_pkg::ST_PARSING;
	logic [7:0]   sinfo [flacmh_pkg::InfoBytes] = '{default: 8'h00};
	int unsigned  body_pos = 0;
	logic [3:0]   chan_limit = 4'd2;

	parse_report_t awaited_reports [$];
	int            fault_count = 0;
	int unsigned   items_sent = 0;
	int unsigned   burst_left = 0;
	defect_t       defect = DEF_NONE;
	logic [3:0]    final_limit = 4'd2;
	logic [7:0]    info_draft [flacmh_pkg::InfoBytes];

	pace_t         pace_mode = PACE_FREE;
	int unsigned   pace_left = 0;
	int unsigned   pace_tick = 0;

	flac_metadata_header_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic parse_report_t decode_info();
		parse_report_t d;
		logic [23:0] w;
		d = '0;
		d.rate = {sinfo[10], sinfo[11], sinfo[12][7:4]};
		d.chans = {1'b0, sinfo[12][3:1]} + 4'd1;
		d.depth = {1'b0, sinfo[12][0], sinfo[13][7:4]} + 6'd1;
		d.max_blk = {sinfo[2], sinfo[3]};
		w = {sinfo[7], sinfo[8], sinfo[9]};
		d.window = (w == 24'd0) ? 24'(flacmh_pkg::DefaultWindow) : w;
		d.samples = {sinfo[13][3:0], sinfo[14], sinfo[15], sinfo[16], sinfo[17]};
		return d;
	endfunction

	function automatic void flag_error(input flacmh_pkg::status_t code);
		err = code;
		walk = W_ERR;
	endfunction

	// returns 1 when the header completes on this block end
	function automatic logic close_block();
		parse_report_t d;
		if (blk_head[6:0] == 7'd0) begin
			if (blk_len != 24'(flacmh_pkg::InfoLen)) begin
				flag_error(flacmh_pkg::ST_BAD_INFO);
				return 1'b0;
			end
			info_seen = 1'b1;
		end
		blk_start += 4 + blk_len;
		if (!blk_head[7]) begin
			walk = W_HEAD;
			hdr_idx = 2'd0;
			return 1'b0;
		end
		d = decode_info();
		if (!info_seen || d.max_blk == 16'd0 || d.chans > chan_limit ||
				(d.depth != 6'd8 && d.depth != 6'd16) || d.rate == 20'd0) begin
			flag_error(flacmh_pkg::ST_BAD_PARAMS);
			return 1'b0;
		end
		if (d.window > flacmh_pkg::MaxWindow) begin
			flag_error(flacmh_pkg::ST_BIG_WINDOW);
			return 1'b0;
		end
		walk = W_DONE;
		return 1'b1;
	endfunction

	function automatic parse_report_t parse_byte(input logic [7:0] b);
		parse_report_t r;
		logic done_now;
		logic pv;
		logic [7:0] pb;
		done_now = 1'b0;
		pv = 1'b0;
		pb = 8'd0;
		case (walk)
			W_MAGIC: begin
				if (b != flacmh_pkg::Magic[hdr_idx]) begin
					flag_error(flacmh_pkg::ST_BAD_MAGIC);
				end else begin
					hdr_idx = hdr_idx + 2'd1;
					if (hdr_idx == 2'd0) begin
						walk = W_HEAD;
						blk_start = 4;
					end
				end
			end
			W_HEAD: begin
				if (hdr_idx == 2'd0) begin
					blk_head = b;
					blk_len = '0;
				end else begin
					blk_len = {blk_len[15:0], b};
				end
				hdr_idx = hdr_idx + 2'd1;
				if (hdr_idx == 2'd0) begin
					if (blk_len > flacmh_pkg::MaxWindow ||
							blk_start + 4 + blk_len > flacmh_pkg::MaxWindow) begin
						flag_error(flacmh_pkg::ST_TOO_LARGE);
					end else begin
						body_pos = 0;
						if (blk_len == 24'd0) done_now = close_block();
						else walk = W_BODY;
					end
				end
			end
			W_BODY: begin
				if (blk_head[6:0] == 7'd0 && body_pos < flacmh_pkg::InfoBytes)
					sinfo[body_pos] = b;
				body_pos++;
				if (body_pos >= blk_len) done_now = close_block();
			end
			W_DONE: begin
				pv = 1'b1;
				pb = b;
			end
			default: ;
		endcase
		r = decode_info();
		if (walk == W_ERR) r.status = err;
		else if (done_now) r.status = flacmh_pkg::ST_HEADER_DONE;
		else if (walk == W_DONE) r.status = flacmh_pkg::ST_PAYLOAD;
		else r.status = flacmh_pkg::ST_PARSING;
		if (walk != W_ERR) begin
			r.pay_valid = pv;
			r.pay_byte = pb;
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- result side

	always @(negedge clk) begin
		if (pace_left == 0) begin
			pace_mode = pace_t'($urandom_range(0, 3));
			pace_left = $urandom_range(16, 200);
		end
		pace_left--;
		pace_tick++;
		case (pace_mode)
			PACE_FREE:     m_tready <= 1'b1;
			PACE_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
			PACE_PERIODIC: m_tready <= ((pace_tick % 7) < 3);
			default:       m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			if (fault_count < 10)
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			fault_count++;
		end
	endtask

	always @(posedge clk) begin : report_check
		parse_report_t got;
		parse_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status    = flacmh_pkg::status_t'(m_tuser[2:0]);
			got.pay_valid = m_tuser[3];
			got.pay_byte  = m_tdata[7:0];
			got.rate      = m_tdata[27:8];
			got.chans     = m_tdata[31:28];
			got.depth     = m_tdata[37:32];
			got.max_blk   = m_tdata[53:38];
			got.window    = m_tdata[77:54];
			got.samples   = m_tdata[113:78];
			if (awaited_reports.size() == 0) begin
				if (fault_count < 10)
					$display("%0t: result transaction with nothing expected", $time);
				fault_count++;
			end else begin
				want = awaited_reports.pop_front();
				check_field("status", want.status, got.status);
				check_field("payload_valid", want.pay_valid, got.pay_valid);
				check_field("payload_byte", want.pay_byte, got.pay_byte);
				check_field("rate_hz", want.rate, got.rate);
				check_field("channel_count", want.chans, got.chans);
				check_field("sample_bits", want.depth, got.depth);
				check_field("largest_block", want.max_blk, got.max_blk);
				check_field("window_bytes", want.window, got.window);
				check_field("sample_total", want.samples, got.samples);
			end
		end
	end

	// ---------------------------------------------------------------- stream side

	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(80, 300)
				: $urandom_range(1, 24);
			if (gap != 0) begin
				@(negedge clk) s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		awaited_reports.push_back(parse_byte(b));
		items_sent++;
	endtask

	task automatic drain_reports();
		@(negedge clk) s_tvalid <= 1'b0;
		while (awaited_reports.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_channel_limit(input logic [3:0] v);
		drain_reports();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		chan_limit = v;
	endtask

	task automatic send_head(input logic [7:0] head, input logic [23:0] len);
		send_byte(head);
		send_byte(len[23:16]);
		send_byte(len[15:8]);
		send_byte(len[7:0]);
	endtask

	// stream info blocks take their first bytes from info_draft
	task automatic send_block(input logic [7:0] head, input int unsigned len);
		send_head(head, 24'(len));
		for (int unsigned i = 0; i < len; i++)
			send_byte((head[6:0] == 7'd0 && i < flacmh_pkg::InfoBytes) ? info_draft[i]
				: 8'($urandom));
	endtask

	function automatic int unsigned body_len();
		return ($urandom_range(0, 7) == 0) ? $urandom_range(60, 250) : $urandom_range(0, 24);
	endfunction

	function automatic void compose_info();
		logic [15:0] max_blk;
		logic [23:0] window;
		logic [19:0] rate;
		logic [3:0]  chans;
		logic [5:0]  depth;
		logic [5:0]  depth_m1;
		logic [35:0] samples;
		int unsigned top;
		max_blk = (defect == DEF_ZERO_BLOCK) ? 16'd0
			: ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom_range(1, 16'hffff));
		rate = (defect == DEF_ZERO_RATE) ? 20'd0
			: ($urandom_range(0, 3) == 0) ? 20'hfffff : 20'($urandom_range(1, 20'hfffff));
		if (defect == DEF_CHANNELS) begin
			chans = 4'($urandom_range(final_limit + 1, 8));
		end else begin
			top = (final_limit > 8 || final_limit == 0) ? 8 : final_limit;
			chans = 4'($urandom_range(1, top));
		end
		if (defect == DEF_DEPTH) begin
			depth = 6'($urandom_range(1, 32));
			if (depth == 6'd8 || depth == 6'd16) depth = depth + 6'd1;
		end else begin
			depth = $urandom_range(0, 1) ? 6'd16 : 6'd8;
		end
		depth_m1 = depth - 6'd1;
		if (defect == DEF_BIG_WINDOW) begin
			window = ($urandom_range(0, 3) == 0) ? 24'hffffff
				: 24'($urandom_range(flacmh_pkg::MaxWindow + 1, 24'hffffff));
		end else begin
			case ($urandom_range(0, 3))
				0:       window = 24'd0;        // falls back to the default window
				1:       window = 24'(flacmh_pkg::MaxWindow);
				default: window = 24'($urandom_range(1, flacmh_pkg::MaxWindow));
			endcase
		end
		samples = ($urandom_range(0, 5) == 0) ? '1 : {4'($urandom), 32'($urandom)};
		for (int i = 0; i < flacmh_pkg::InfoBytes; i++) info_draft[i] = 8'($urandom);
		{info_draft[2], info_draft[3]} = max_blk;
		{info_draft[7], info_draft[8], info_draft[9]} = window;
		info_draft[10] = rate[19:12];
		info_draft[11] = rate[11:4];
		info_draft[12] = {rate[3:0], 3'(chans - 4'd1), depth_m1[4]};
		info_draft[13] = {depth_m1[3:0], samples[35:32]};
		{info_draft[14], info_draft[15], info_draft[16], info_draft[17]} = samples[31:0];
	endfunction

	// ---------------------------------------------------------------- tests

	task automatic test_magic();
		int unsigned bad_at;
		bad_at = (defect == DEF_BAD_MAGIC) ? $urandom_range(0, 3) : 4;
		for (int i = 0; i < 4; i++) begin
			if (i == bad_at) begin
				send_byte(flacmh_pkg::Magic[i] ^ 8'($urandom_range(1, 255)));
				return;
			end
			send_byte(flacmh_pkg::Magic[i]);
		end
	endtask

	task automatic test_metadata_walk();
		int unsigned n_back;
		int unsigned len;
		if (defect == DEF_BAD_MAGIC) return;
		// zero limit while the header is still open has no effect on the outcome
		set_channel_limit(4'd0);
		send_block(8'h01, 0);
		send_block(8'h7f, $urandom_range(1, 6));
		// an early stream info that a later one overwrites
		if (defect != DEF_NO_INFO && $urandom_range(0, 2) == 0) begin
			for (int i = 0; i < flacmh_pkg::InfoBytes; i++) info_draft[i] = 8'($urandom);
			send_block(8'h00, flacmh_pkg::InfoLen);
		end
		repeat ($urandom_range(0, 3)) send_block(8'($urandom_range(1, 127)), body_len());
		if (defect == DEF_OVERSIZE) begin
			if ($urandom_range(0, 1))
				len = $urandom_range(flacmh_pkg::MaxWindow + 1, 24'hffffff);
			else
				len = flacmh_pkg::MaxWindow - blk_start - 3 + $urandom_range(0, 2);
			send_head(8'($urandom), 24'(len));
			return;
		end
		set_channel_limit(final_limit);
		n_back = $urandom_range(0, 2);
		if (defect == DEF_NO_INFO) begin
			n_back = $urandom_range(1, 2);
		end else begin
			compose_info();
			len = flacmh_pkg::InfoLen;
			if (defect == DEF_INFO_LENGTH) begin
				case ($urandom_range(0, 3))
					0:       len = 0;
					1:       len = flacmh_pkg::InfoLen - 1;
					2:       len = flacmh_pkg::InfoLen + 1;
					default: len = $urandom_range(1, 60);
				endcase
				if (len == flacmh_pkg::InfoLen) len = 60;
			end
			send_block({n_back == 0, 7'd0}, len);
			if (defect == DEF_INFO_LENGTH) return;
		end
		for (int unsigned i = 1; i <= n_back; i++)
			send_block({i == n_back, 7'($urandom_range(1, 127))}, body_len());
	endtask

	task automatic test_payload_stream();
		logic [3:0] limits [3];
		limits = '{4'd8, 4'd1, 4'($urandom_range(0, 15))};
		send_byte(8'h00);
		send_byte(8'hff);
		for (int k = 0; k < 3; k++) begin
			while (items_sent < ItemGoal * (k + 1) / 3) send_byte(8'($urandom));
			set_channel_limit(limits[k]);
		end
	endtask

	initial begin
		int unsigned draw;
		draw = $urandom_range(0, 19);
		defect = (draw < 10) ? DEF_NONE : defect_t'(draw - 9);
		case (defect)
			DEF_ZERO_LIMIT: final_limit = 4'd0;
			DEF_CHANNELS:   final_limit = 4'($urandom_range(1, 7));
			default:        final_limit = ($urandom_range(0, 3) == 0) ? 4'd15
				: 4'($urandom_range(1, 8));
		endcase
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		set_channel_limit(4'd15);
		test_magic();
		test_metadata_walk();
		test_payload_stream();
		drain_reports();
		repeat (8) @(posedge clk);
		if (fault_count == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

	initial begin
		#(4_000_000);
		$display("TEST FAILED");
		$finish;
	end

endmodule
